@@ rtl/kmp_pkg.sv @@
// ----------------------------------------------------------------------------
// kmp_pkg
// shared constants and controller/datapath interface types for the kmp matcher
// ----------------------------------------------------------------------------
package kmp_pkg;

    // capacities
    localparam int MAX_PATTERN = 256;
    localparam int MAX_TEXT    = 2048;

    // derived widths
    localparam int PAT_AW = $clog2(MAX_PATTERN);     // pattern store index
    localparam int LEN_W  = PAT_AW + 1;              // pattern length, prefix length
    localparam int TCNT_W = $clog2(MAX_TEXT + 1);    // kept text bytes
    localparam int POS_W  = 12;                      // result position field

    // command field codes
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic pat_load;     // store a pattern byte from the input port
        logic txt_capture;  // latch a text byte and its last flag
        logic build_init;   // first link, start of the link build
        logic build_step;   // one compare of the link build
        logic build_link;   // link build falls back one link
        logic txt_check;    // capacity and empty-pattern checks for a text byte
        logic txt_step;     // one compare of the text scan
        logic txt_link;     // text scan falls back one link
        logic result_load;  // load the result register, clear text state
    } kmp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic complete;     // links are built for the current pattern
        logic len_le1;      // pattern has at most one byte
        logic build_fall;   // link build compare missed with a nonzero border
        logic build_last;   // link build is at the last pattern position
        logic txt_go;       // text byte has to be compared
        logic txt_fall;     // text compare missed with a nonzero prefix
        logic last_item;    // latched text byte closes the text
    } kmp_sts_t;

endpackage

@@ rtl/kmp_string_matcher_top.sv @@
// ----------------------------------------------------------------------------
// kmp_string_matcher_top
// streaming knuth-morris-pratt search: pattern bytes, then text bytes, one
// found/position/overflow result per text
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------
//  input    | in_valid / in_ready   | command, data_byte, is_last
//  output   | out_valid / out_ready | found, position, overflow
//
// the last pattern byte starts the link build: a first step, then a compare
// per pattern position, plus a link step and a fresh compare on every border
// fallback; a text byte goes through transfer, capacity check, compare and
// finish, plus a link step and a fresh compare per fallback step, and skips
// the compare when the byte is skipped (after a match, with an empty pattern or
// past text capacity); a text byte that closes an open pattern also waits for
// the link build, and the fallback walk through the link store sets the pace
// reset is asynchronous active low; the pattern and link stores are not
// cleared, only entries below the pattern length are ever used
// a result waits in the output register; text ending while it still waits
// holds in the finish step until that result is transferred
// ----------------------------------------------------------------------------
module kmp_string_matcher_top
    import kmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [7:0]        data_byte,
    input  logic              is_last,
    // output channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic              found,
    output logic [POS_W-1:0]  position,
    output logic              overflow
);

    kmp_cmd_t cmd;
    kmp_sts_t sts;

    // sequencer: owns both handshakes and the result valid flag
    kmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // stores, counters and the result register
    kmp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (data_byte),
        .is_last   (is_last),
        .sts       (sts),
        .found     (found),
        .position  (position),
        .overflow  (overflow)
    );

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // at most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("kmp: more than one datapath command in a cycle");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> (!out_valid || out_ready))
        else $error("kmp: result register loaded while a result is pending");

    // text is only scanned once the links of the pattern are built
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.txt_check || cmd.txt_step || cmd.txt_link) |-> sts.complete)
        else $error("kmp: text scanned before the link build finished");

    // a match always starts inside the kept text
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (position < POS_W'(MAX_TEXT)))
        else $error("kmp: match position beyond text capacity");

endmodule

@@ rtl/kmp_datapath.sv @@
// ----------------------------------------------------------------------------
// kmp_datapath
// pattern store, failure link store, match and text counters, result register
// ----------------------------------------------------------------------------
module kmp_datapath
    import kmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  kmp_cmd_t          cmd,
    input  logic [7:0]        data_byte,
    input  logic              is_last,
    output kmp_sts_t          sts,
    output logic              found,
    output logic [POS_W-1:0]  position,
    output logic              overflow
);

    logic [7:0]        pattern_mem [MAX_PATTERN];
    logic [LEN_W-1:0]  link_mem    [MAX_PATTERN];

    logic [LEN_W-1:0]  len_reg;
    logic              complete_reg;
    logic [LEN_W-1:0]  mp_reg;
    logic [TCNT_W-1:0] tcount_reg;
    logic              ms_reg;
    logic              ovf_reg;
    logic [LEN_W-1:0]  j_reg;
    logic [LEN_W-1:0]  k_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic [7:0]        pa_reg;
    logic [7:0]        pb_reg;
    logic [LEN_W-1:0]  link_rd_reg;
    logic              found_reg;
    logic [POS_W-1:0]  position_reg;
    logic              overflow_reg;

    logic              pat_we;
    logic [PAT_AW-1:0] pat_waddr;
    logic              pa_re;
    logic [PAT_AW-1:0] pa_addr;
    logic              pb_re;
    logic [PAT_AW-1:0] pb_addr;
    logic              lk_we;
    logic [PAT_AW-1:0] lk_waddr;
    logic [LEN_W-1:0]  lk_wdata;
    logic              lk_re;
    logic [PAT_AW-1:0] lk_raddr;
    logic [LEN_W-1:0]  k_inc;
    logic [LEN_W-1:0]  j_inc;
    logic [LEN_W-1:0]  mp_inc;
    logic              len_zero;
    logic              len_room;
    logic              text_room;
    logic [TCNT_W-1:0] match_start;

    assign len_zero  = (len_reg == '0);
    assign len_room  = (len_reg < LEN_W'(MAX_PATTERN));
    assign text_room = (tcount_reg < TCNT_W'(MAX_TEXT));
    assign k_inc     = k_reg + LEN_W'(pa_reg == pb_reg);
    assign j_inc     = j_reg + LEN_W'(1);
    assign mp_inc    = mp_reg + LEN_W'(byte_reg == pa_reg);
    assign match_start = tcount_reg - TCNT_W'(len_reg);

    // status
    assign sts.complete   = complete_reg;
    assign sts.len_le1    = (len_reg <= LEN_W'(1));
    assign sts.build_fall = (k_reg != '0) && (pa_reg != pb_reg);
    assign sts.build_last = (j_inc == len_reg);
    assign sts.txt_go     = !ms_reg && !len_zero && text_room;
    assign sts.txt_fall   = (mp_reg != '0) && (byte_reg != pa_reg);
    assign sts.last_item  = last_reg;

    // memory port steering
    always_comb
    begin
        pat_we    = cmd.pat_load && (complete_reg || len_room);
        pat_waddr = complete_reg ? '0 : len_reg[PAT_AW-1:0];

        pa_re   = cmd.build_init || (cmd.build_step && !sts.build_fall) || cmd.build_link
                  || (cmd.txt_check && sts.txt_go) || cmd.txt_link;
        pa_addr = '0;
        if (cmd.build_init)
            pa_addr = PAT_AW'(1);
        else if (cmd.build_step)
            pa_addr = j_inc[PAT_AW-1:0];
        else if (cmd.build_link)
            pa_addr = j_reg[PAT_AW-1:0];
        else if (cmd.txt_check)
            pa_addr = mp_reg[PAT_AW-1:0];
        else if (cmd.txt_link)
            pa_addr = link_rd_reg[PAT_AW-1:0];

        pb_re   = cmd.build_init || (cmd.build_step && !sts.build_fall) || cmd.build_link;
        pb_addr = '0;
        if (cmd.build_step)
            pb_addr = k_inc[PAT_AW-1:0];
        else if (cmd.build_link)
            pb_addr = link_rd_reg[PAT_AW-1:0];

        lk_we    = cmd.build_init || (cmd.build_step && !sts.build_fall);
        lk_waddr = cmd.build_init ? '0 : j_reg[PAT_AW-1:0];
        lk_wdata = cmd.build_init ? '0 : k_inc;

        lk_re    = (cmd.build_step && sts.build_fall) || (cmd.txt_step && sts.txt_fall);
        lk_raddr = cmd.build_step ? PAT_AW'(k_reg - LEN_W'(1))
                                  : PAT_AW'(mp_reg - LEN_W'(1));
    end

    // memories with registered reads
    always_ff @(posedge clk)
    begin
        if (pat_we)
            pattern_mem[pat_waddr] <= data_byte;
        if (pa_re)
            pa_reg <= pattern_mem[pa_addr];
        if (pb_re)
            pb_reg <= pattern_mem[pb_addr];
        if (lk_we)
            link_mem[lk_waddr] <= lk_wdata;
        if (lk_re)
            link_rd_reg <= link_mem[lk_raddr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.build_init || cmd.build_step || cmd.build_link)
        begin
            if (cmd.build_init)
            begin
                j_reg <= LEN_W'(1);
                k_reg <= '0;
            end
            else if (cmd.build_step && !sts.build_fall)
            begin
                j_reg <= j_inc;
                k_reg <= k_inc;
            end
            else if (cmd.build_link)
                k_reg <= link_rd_reg;
        end
        if (cmd.txt_capture)
        begin
            byte_reg <= data_byte;
            last_reg <= is_last;
        end
        if (cmd.result_load)
        begin
            found_reg    <= ms_reg;
            position_reg <= POS_W'(ms_reg ? match_start : tcount_reg);
            overflow_reg <= ovf_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            complete_reg <= 1'b1;
            mp_reg       <= '0;
            tcount_reg   <= '0;
            ms_reg       <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.pat_load)
            begin
                if (complete_reg)
                begin
                    // first byte of a new pattern
                    complete_reg <= 1'b0;
                    len_reg      <= LEN_W'(1);
                    ovf_reg      <= 1'b0;
                    mp_reg       <= '0;
                    tcount_reg   <= '0;
                    ms_reg       <= 1'b0;
                end
                else if (len_room)
                    len_reg <= len_reg + LEN_W'(1);
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.build_init && sts.len_le1)
                complete_reg <= 1'b1;
            if (cmd.build_step && !sts.build_fall && sts.build_last)
                complete_reg <= 1'b1;
            if (cmd.txt_check)
            begin
                if (len_zero)
                    ms_reg <= 1'b1;
                else if (!ms_reg)
                begin
                    if (text_room)
                        tcount_reg <= tcount_reg + TCNT_W'(1);
                    else
                        ovf_reg <= 1'b1;
                end
            end
            if (cmd.txt_step && !sts.txt_fall)
            begin
                mp_reg <= mp_inc;
                if (mp_inc >= len_reg)
                    ms_reg <= 1'b1;
            end
            if (cmd.txt_link)
                mp_reg <= link_rd_reg;
            if (cmd.result_load)
            begin
                mp_reg     <= '0;
                tcount_reg <= '0;
                ms_reg     <= 1'b0;
            end
        end
    end

    assign found    = found_reg;
    assign position = position_reg;
    assign overflow = overflow_reg;

endmodule

@@ rtl/kmp_ctrl.sv @@
// ----------------------------------------------------------------------------
// kmp_ctrl
// sequencer for pattern load, link build, text scan and result handoff
// ----------------------------------------------------------------------------
module kmp_ctrl
    import kmp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      command,
    input  logic      is_last,
    output logic      out_valid,
    input  logic      out_ready,
    output kmp_cmd_t  cmd,
    input  kmp_sts_t  sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TCHK,
        S_BINIT,
        S_BCMP,
        S_BLINK,
        S_TCMP,
        S_TLINK,
        S_TDONE
    } state_t;

    state_t state_reg;
    logic   from_text_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.pat_load    = in_valid && (command == CMD_PATTERN);
                cmd.txt_capture = in_valid && (command == CMD_TEXT);
            end
            S_TCHK:  cmd.txt_check   = sts.complete;
            S_BINIT: cmd.build_init  = 1'b1;
            S_BCMP:  cmd.build_step  = 1'b1;
            S_BLINK: cmd.build_link  = 1'b1;
            S_TCMP:  cmd.txt_step    = 1'b1;
            S_TLINK: cmd.txt_link    = 1'b1;
            S_TDONE: cmd.result_load = sts.last_item && out_free;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            from_text_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.result_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (command == CMD_TEXT)
                            state_reg <= S_TCHK;
                        else if (is_last)
                        begin
                            from_text_reg <= 1'b0;
                            state_reg     <= S_BINIT;
                        end
                    end
                end
                S_TCHK:
                begin
                    if (!sts.complete)
                    begin
                        from_text_reg <= 1'b1;
                        state_reg     <= S_BINIT;
                    end
                    else if (sts.txt_go)
                        state_reg <= S_TCMP;
                    else
                        state_reg <= S_TDONE;
                end
                S_BINIT:
                begin
                    if (!sts.len_le1)
                        state_reg <= S_BCMP;
                    else if (from_text_reg)
                        state_reg <= S_TCHK;
                    else
                        state_reg <= S_IDLE;
                end
                S_BCMP:
                begin
                    if (sts.build_fall)
                        state_reg <= S_BLINK;
                    else if (sts.build_last)
                        state_reg <= from_text_reg ? S_TCHK : S_IDLE;
                end
                S_BLINK: state_reg <= S_BCMP;
                S_TCMP:  state_reg <= sts.txt_fall ? S_TLINK : S_TDONE;
                S_TLINK: state_reg <= S_TCMP;
                S_TDONE:
                begin
                    if (!sts.last_item || out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ dv/kmp_match_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_match_checker
// watches both channels of the matcher, tracks the search on its own and
// compares every result transfer against the oldest predicted result
// ----------------------------------------------------------------------------
module kmp_match_checker
    import kmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              command,
    input  logic [7:0]        data_byte,
    input  logic              is_last,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              found,
    input  logic [POS_W-1:0]  position,
    input  logic              overflow,
    output int                fail_count,
    output int                pending,
    output int                results_seen,
    output int                hits_seen,
    output int                overflows_seen
);

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  position;
        logic              overflow;
    } search_result_t;

    search_result_t     predicted_results[$];
    search_result_t     want;
    search_result_t     got;

    // shadow of the search state
    logic [7:0]         pat_mem    [MAX_PATTERN];
    logic [LEN_W-1:0]   border_mem [MAX_PATTERN];
    logic [LEN_W-1:0]   pat_len;
    logic               pat_ready;
    logic [LEN_W-1:0]   prefix_len;
    logic [TCNT_W-1:0]  kept_text;
    logic               hit;
    logic               dropped;

    int                 errors;
    int                 n_results;
    int                 n_hits;
    int                 n_overflows;

    function automatic void clear_scan();
        prefix_len = '0;
        kept_text  = '0;
        hit        = 1'b0;
    endfunction

    // longest proper border of every prefix of the stored pattern
    function automatic void build_borders();
        logic [LEN_W-1:0] k;
        k = '0;
        if (pat_len != 0)
        begin
            border_mem[0] = '0;
            for (int j = 1; j < pat_len; j++)
            begin
                while (k > 0 && pat_mem[j] != pat_mem[k])
                    k = border_mem[k - 1];
                if (pat_mem[j] == pat_mem[k])
                    k++;
                border_mem[j] = k;
            end
        end
        pat_ready = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len   = '0;
            pat_ready = 1'b1;
            dropped   = 1'b0;
            clear_scan();
            predicted_results.delete();
            errors      = 0;
            n_results   = 0;
            n_hits      = 0;
            n_overflows = 0;
            fail_count     <= 0;
            pending        <= 0;
            results_seen   <= 0;
            hits_seen      <= 0;
            overflows_seen <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (command == CMD_PATTERN)
                begin
                    // first byte after a finished pattern starts a new one
                    if (pat_ready)
                    begin
                        pat_ready = 1'b0;
                        pat_len   = '0;
                        dropped   = 1'b0;
                        clear_scan();
                    end
                    if (pat_len < MAX_PATTERN)
                    begin
                        pat_mem[pat_len] = data_byte;
                        pat_len++;
                    end
                    else
                        dropped = 1'b1;
                    if (is_last)
                        build_borders();
                end
                else
                begin
                    // text cuts a pattern load short
                    if (!pat_ready)
                        build_borders();
                    if (pat_len == 0)
                        hit = 1'b1;
                    if (!hit)
                    begin
                        if (kept_text >= MAX_TEXT)
                            dropped = 1'b1;
                        else
                        begin
                            kept_text++;
                            while (prefix_len > 0 && data_byte != pat_mem[prefix_len])
                                prefix_len = border_mem[prefix_len - 1];
                            if (data_byte == pat_mem[prefix_len])
                                prefix_len++;
                            if (prefix_len >= pat_len)
                                hit = 1'b1;
                        end
                    end
                    if (is_last)
                    begin
                        want.found    = hit;
                        want.position = hit ? POS_W'(kept_text - pat_len) : POS_W'(kept_text);
                        want.overflow = dropped;
                        predicted_results.push_back(want);
                        clear_scan();
                    end
                end
            end

            if (out_valid && out_ready)
            begin
                got = '{found, position, overflow};
                n_results++;
                if (found === 1'b1)
                    n_hits++;
                if (overflow === 1'b1)
                    n_overflows++;
                if (predicted_results.size() == 0)
                begin
                    $error("result transfer with no result pending");
                    errors++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, got.found);
                        errors++;
                    end
                    if (got.position !== want.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               want.position, got.position);
                        errors++;
                    end
                    if (got.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0d, actual %0d",
                               want.overflow, got.overflow);
                        errors++;
                    end
                end
            end

            fail_count     <= errors;
            pending        <= predicted_results.size();
            results_seen   <= n_results;
            hits_seen      <= n_hits;
            overflows_seen <= n_overflows;
        end
    end

endmodule

@@ dv/kmp_string_matcher_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_string_matcher_top_tb
// drives patterns and texts into the matcher with random gaps on both
// channels and leaves all checking to kmp_match_checker
// ----------------------------------------------------------------------------
module kmp_string_matcher_top_tb;
    import kmp_pkg::*;

    localparam int RUN_LIMIT_NS = 6_000_000;   // far above the slowest legal run
    localparam int HOLD_CYCLES  = 400;         // long receiver hold-off
    localparam int DRAIN_CYCLES = 64;          // settle time after the last result
    localparam int RANDOM_ITEMS = 1050;        // byte budget up to the capacity part
    localparam int IDLE_PCT     = 33;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              command   = CMD_PATTERN;
    logic [7:0]        data_byte = 8'h00;
    logic              is_last   = 1'b0;
    logic              out_ready = 1'b0;
    logic              in_ready;
    logic              out_valid;
    logic              found;
    logic [POS_W-1:0]  position;
    logic              overflow;

    int fail_count;
    int pending;
    int results_seen;
    int hits_seen;
    int overflows_seen;

    // gap and hold-off controls shared by the sender and receiver, and the sender's byte count
    bit no_idle      = 1'b0;   // both sides run without gaps
    bit hold_request = 1'b0;   // receiver holds off for HOLD_CYCLES
    int bytes_sent   = 0;

    // current pattern and text under construction
    logic [7:0] pat_q[$];
    logic [7:0] text_q[$];
    logic [7:0] alpha[4];
    int         alpha_n      = 2;
    bit         wide_symbols = 1'b1;

    kmp_string_matcher_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .data_byte (data_byte),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .position  (position),
        .overflow  (overflow)
    );

    kmp_match_checker match_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .data_byte      (data_byte),
        .is_last        (is_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .position       (position),
        .overflow       (overflow),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_seen   (results_seen),
        .hits_seen      (hits_seen),
        .overflows_seen (overflows_seen)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard stop in case the matcher hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request so the result
    // register stays full and the matcher has to stall its input
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end
            else
                out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // one input transfer; valid stays up with a steady payload until accepted,
    // and is left high so back-to-back bytes need no second assignment
    task automatic push_byte(input logic cmd, input logic [7:0] value, input logic last);
        if (!no_idle)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        data_byte <= value;
        is_last   <= last;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // close = 0 leaves the pattern open so the next text byte finishes it
    task automatic send_pattern(input bit close);
        foreach (pat_q[i])
            push_byte(CMD_PATTERN, pat_q[i], close && (i == pat_q.size() - 1));
    endtask

    task automatic send_text();
        foreach (text_q[i])
            push_byte(CMD_TEXT, text_q[i], i == text_q.size() - 1);
    endtask

    // small alphabets give repeated borders and fallback walks
    function automatic logic [7:0] pick_symbol();
        return wide_symbols ? 8'($urandom_range(255)) : alpha[$urandom_range(alpha_n - 1)];
    endfunction

    // mostly short patterns, now and then one near or at full capacity
    function automatic void make_pattern();
        int len;
        int r;
        alpha_n = $urandom_range(2, 4);
        foreach (alpha[i])
            alpha[i] = 8'($urandom_range(255));
        wide_symbols = ($urandom_range(9) == 0);
        r = $urandom_range(99);
        if (r < 70)
            len = $urandom_range(1, 6);
        else if (r < 96)
            len = $urandom_range(7, 24);
        else
            len = $urandom_range(1) ? MAX_PATTERN : $urandom_range(200, MAX_PATTERN - 1);
        pat_q.delete();
        repeat (len) pat_q.push_back(pick_symbol());
    endfunction

    // text over the pattern's alphabet, sometimes with a copy of the pattern
    // or a near miss (last byte flipped) planted at a random spot
    function automatic void make_text(input int len, input bit plant);
        int         at;
        logic [7:0] piece[$];
        text_q.delete();
        repeat (len) text_q.push_back(pick_symbol());
        if (plant && pat_q.size() > 0 && $urandom_range(99) < 45)
        begin
            piece = pat_q;
            if ($urandom_range(3) == 0)
                piece[piece.size() - 1] ^= 8'h01;
            at = $urandom_range(text_q.size());
            foreach (piece[i])
                text_q.insert(at + i, piece[i]);
        end
    endfunction

    initial
    begin : stimulus
        int pick;
        bit pressured;
        pressured = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // ---------------- directed part ----------------
        // empty pattern right after reset: always found at zero
        text_q = '{8'h00};
        send_text();
        text_q = '{8'hFF, 8'h5A};
        send_text();
        // extreme byte values, match not at the start
        pat_q = '{8'h00, 8'hFF, 8'h00};
        send_pattern(1'b1);
        text_q = '{8'hFF, 8'h00, 8'hFF, 8'h00};
        send_text();
        // miss reports the text length
        text_q = '{8'h00, 8'hFF, 8'h01};
        send_text();
        // text arriving mid-pattern closes the pattern with what was stored
        pat_q = '{8'hAA, 8'hAB};
        send_pattern(1'b0);
        text_q = '{8'hAA, 8'hAB};
        send_text();
        // one-byte pattern
        pat_q = '{8'h7F};
        send_pattern(1'b1);
        text_q = '{8'h7E, 8'h7F};
        send_text();
        // mismatch after a partial match falls back through a border
        pat_q = '{8'h41, 8'h41, 8'h42};
        send_pattern(1'b1);
        text_q = '{8'h41, 8'h41, 8'h41, 8'h42};
        send_text();

        // ---------------- random part ----------------
        while (bytes_sent < RANDOM_ITEMS)
        begin
            // a stretch with no gaps on either side
            no_idle = (bytes_sent >= 150 && bytes_sent < 450);

            // receiver holds off while several short texts queue up behind
            // the waiting result
            if (!pressured && bytes_sent >= 800)
            begin
                pressured    = 1'b1;
                hold_request = 1'b1;
                repeat (6)
                begin
                    make_text($urandom_range(1, 3), 1'b0);
                    send_text();
                end
            end

            pick = $urandom_range(99);
            if (pick < 12)
            begin
                make_pattern();
                send_pattern(1'b1);
            end
            else if (pick < 18)
            begin
                // broken load: pattern left open, text takes over
                make_pattern();
                send_pattern(1'b0);
                make_text($urandom_range(1, 24), 1'b1);
                send_text();
            end
            else if (pick < 24)
            begin
                // noise: bytes from the whole range
                text_q.delete();
                repeat ($urandom_range(1, 16)) text_q.push_back(8'($urandom_range(255)));
                send_text();
            end
            else
            begin
                make_text(($urandom_range(99) < 85) ? $urandom_range(1, 24)
                                                    : $urandom_range(25, 64), 1'b1);
                send_text();
            end
        end
        no_idle = 1'b0;

        // ---------------- capacity ----------------
        // pattern past capacity: overflow reported and kept for later texts
        pat_q.delete();
        repeat (MAX_PATTERN + 4) pat_q.push_back(8'($urandom_range(255)));
        send_pattern(1'b1);
        repeat (2)
        begin
            text_q.delete();
            repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(255)));
            send_text();
        end
        // a new pattern clears the overflow
        pat_q = '{8'h33};
        send_pattern(1'b1);
        text_q = '{8'h33};
        send_text();

        // ---------------- wind down ----------------
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d byte transfers, %0d results checked, %0d matches, %0d overflows",
                 bytes_sent, results_seen, hits_seen, overflows_seen);
        $display("run: empty and open patterns, fallbacks, full-size and overlong patterns");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/kmp_pkg.sv
rtl/kmp_datapath.sv
rtl/kmp_ctrl.sv
rtl/kmp_string_matcher_top.sv
dv/kmp_match_checker.sv
dv/kmp_string_matcher_top_tb.sv
